>>> rtl/cnkn_pkg.sv
package cnkn_pkg;

  localparam logic [15:0] DENSITY_Q16 = 16'd26093;
  localparam logic [31:0] HASH_X      = 32'd702395077;
  localparam logic [31:0] HASH_Y      = 32'd915488749;
  localparam logic [31:0] HASH_Z      = 32'd2120969693;
  localparam logic [31:0] LCG_MUL     = 32'd1402024253;
  localparam logic [31:0] LCG_ADD     = 32'd586950981;
  localparam logic [31:0] EMPTY_DIST  = 32'hFFFF_FFFF;
  localparam logic [2:0]  ORDER_RST   = 3'd4;
  localparam logic [19:0] OUT_MAX     = 20'hF_FFFF;
  localparam int          DELTA_W     = 19;
  localparam int          QDEPTH      = 4;
  localparam int          QPW         = $clog2(QDEPTH);
  localparam logic [4:0]  LAST_CUBE   = 5'd26;

  localparam logic [1:0] OFF_M = 2'b11;
  localparam logic [1:0] OFF_Z = 2'b00;
  localparam logic [1:0] OFF_P = 2'b01;

  typedef struct packed {
    logic signed [1:0] x;
    logic signed [1:0] y;
    logic signed [1:0] z;
  } cnkn_off_t;

  typedef struct packed {
    logic [1:0]                rank;
    logic                      found;
    logic                      last;
    logic [31:0]               d2;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [DELTA_W-1:0] dz;
    logic [31:0]               id;
  } cnkn_entry_t;

  localparam logic [2:0] PT_CNT_ROM [0:255] = '{
    3'd4,3'd3,3'd1,3'd1,3'd1,3'd2,3'd4,3'd2,3'd2,3'd2,3'd5,3'd1,3'd0,3'd2,3'd1,3'd2,
    3'd2,3'd0,3'd4,3'd3,3'd2,3'd1,3'd2,3'd1,3'd3,3'd2,3'd2,3'd4,3'd2,3'd2,3'd5,3'd1,
    3'd2,3'd3,3'd2,3'd2,3'd2,3'd2,3'd2,3'd3,3'd2,3'd4,3'd2,3'd5,3'd3,3'd2,3'd2,3'd2,
    3'd5,3'd3,3'd3,3'd5,3'd2,3'd1,3'd3,3'd3,3'd4,3'd4,3'd2,3'd3,3'd0,3'd4,3'd2,3'd2,
    3'd2,3'd1,3'd3,3'd2,3'd2,3'd2,3'd3,3'd3,3'd3,3'd1,3'd2,3'd0,3'd2,3'd1,3'd1,3'd2,
    3'd2,3'd2,3'd2,3'd5,3'd3,3'd2,3'd3,3'd2,3'd3,3'd2,3'd2,3'd1,3'd0,3'd2,3'd1,3'd1,
    3'd2,3'd1,3'd2,3'd2,3'd1,3'd3,3'd4,3'd2,3'd2,3'd2,3'd5,3'd4,3'd2,3'd4,3'd2,3'd2,
    3'd5,3'd4,3'd3,3'd2,3'd2,3'd5,3'd4,3'd3,3'd3,3'd3,3'd5,3'd2,3'd2,3'd2,3'd2,3'd2,
    3'd3,3'd1,3'd1,3'd4,3'd2,3'd1,3'd3,3'd3,3'd4,3'd3,3'd2,3'd4,3'd3,3'd3,3'd3,3'd4,
    3'd5,3'd1,3'd4,3'd2,3'd4,3'd3,3'd1,3'd2,3'd3,3'd5,3'd3,3'd2,3'd1,3'd3,3'd1,3'd3,
    3'd3,3'd3,3'd2,3'd3,3'd1,3'd5,3'd5,3'd4,3'd2,3'd2,3'd4,3'd1,3'd3,3'd4,3'd1,3'd5,
    3'd3,3'd3,3'd5,3'd3,3'd4,3'd3,3'd2,3'd2,3'd1,3'd1,3'd1,3'd1,3'd1,3'd2,3'd4,3'd5,
    3'd4,3'd5,3'd4,3'd2,3'd1,3'd5,3'd1,3'd1,3'd2,3'd3,3'd3,3'd3,3'd2,3'd5,3'd2,3'd3,
    3'd3,3'd2,3'd0,3'd2,3'd1,3'd1,3'd4,3'd2,3'd1,3'd3,3'd2,3'd1,3'd2,3'd2,3'd3,3'd2,
    3'd5,3'd5,3'd3,3'd4,3'd5,3'd5,3'd2,3'd4,3'd4,3'd5,3'd3,3'd2,3'd2,3'd2,3'd1,3'd4,
    3'd2,3'd3,3'd3,3'd4,3'd2,3'd5,3'd4,3'd2,3'd4,3'd2,3'd2,3'd2,3'd4,3'd5,3'd3,3'd2
  };

  // cube 0 is the home cube, then faces, edges and corners
  function automatic cnkn_off_t cnkn_offset(input logic [4:0] n);
    cnkn_off_t o;
    case (n)
      5'd1:    o = '{OFF_M, OFF_Z, OFF_Z};
      5'd2:    o = '{OFF_Z, OFF_M, OFF_Z};
      5'd3:    o = '{OFF_Z, OFF_Z, OFF_M};
      5'd4:    o = '{OFF_P, OFF_Z, OFF_Z};
      5'd5:    o = '{OFF_Z, OFF_P, OFF_Z};
      5'd6:    o = '{OFF_Z, OFF_Z, OFF_P};
      5'd7:    o = '{OFF_M, OFF_M, OFF_Z};
      5'd8:    o = '{OFF_M, OFF_Z, OFF_M};
      5'd9:    o = '{OFF_Z, OFF_M, OFF_M};
      5'd10:   o = '{OFF_P, OFF_P, OFF_Z};
      5'd11:   o = '{OFF_P, OFF_Z, OFF_P};
      5'd12:   o = '{OFF_Z, OFF_P, OFF_P};
      5'd13:   o = '{OFF_M, OFF_P, OFF_Z};
      5'd14:   o = '{OFF_M, OFF_Z, OFF_P};
      5'd15:   o = '{OFF_Z, OFF_M, OFF_P};
      5'd16:   o = '{OFF_P, OFF_M, OFF_Z};
      5'd17:   o = '{OFF_P, OFF_Z, OFF_M};
      5'd18:   o = '{OFF_Z, OFF_P, OFF_M};
      5'd19:   o = '{OFF_M, OFF_M, OFF_M};
      5'd20:   o = '{OFF_M, OFF_M, OFF_P};
      5'd21:   o = '{OFF_M, OFF_P, OFF_M};
      5'd22:   o = '{OFF_M, OFF_P, OFF_P};
      5'd23:   o = '{OFF_P, OFF_M, OFF_M};
      5'd24:   o = '{OFF_P, OFF_M, OFF_P};
      5'd25:   o = '{OFF_P, OFF_P, OFF_M};
      5'd26:   o = '{OFF_P, OFF_P, OFF_P};
      default: o = '{OFF_Z, OFF_Z, OFF_Z};
    endcase
    return o;
  endfunction

  function automatic logic [DELTA_W-2:0] cnkn_mag(input logic signed [DELTA_W-1:0] v);
    logic [DELTA_W-1:0] m;
    m = v[DELTA_W-1] ? -v : v;
    return m[DELTA_W-2:0];
  endfunction

endpackage

>>> rtl/cnkn_search.sv
module cnkn_search import cnkn_pkg::*; #(
  parameter int NEAR_SLOTS = 4,
  localparam int KW = $clog2(NEAR_SLOTS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [95:0]   in_tdata,
  input  logic [KW-1:0] k,
  output logic          q_valid,
  input  logic          q_ready,
  output cnkn_entry_t   q_data
);

  localparam int IW = (NEAR_SLOTS > 1) ? $clog2(NEAR_SLOTS) : 1;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SC   = 5'd1;
  localparam logic [4:0] ST_SCW  = 5'd2;
  localparam logic [4:0] ST_LOI  = 5'd3;
  localparam logic [4:0] ST_LOW  = 5'd4;
  localparam logic [4:0] ST_HIW  = 5'd5;
  localparam logic [4:0] ST_CUBE = 5'd6;
  localparam logic [4:0] ST_H1   = 5'd7;
  localparam logic [4:0] ST_H2   = 5'd8;
  localparam logic [4:0] ST_H3   = 5'd9;
  localparam logic [4:0] ST_LI   = 5'd10;
  localparam logic [4:0] ST_LW   = 5'd11;
  localparam logic [4:0] ST_PT   = 5'd12;
  localparam logic [4:0] ST_DX   = 5'd13;
  localparam logic [4:0] ST_Q0   = 5'd14;
  localparam logic [4:0] ST_Q1   = 5'd15;
  localparam logic [4:0] ST_Q2   = 5'd16;
  localparam logic [4:0] ST_Q3   = 5'd17;
  localparam logic [4:0] ST_INS  = 5'd18;
  localparam logic [4:0] ST_NXT  = 5'd19;
  localparam logic [4:0] ST_EM   = 5'd20;

  localparam logic [2:0] LC_FZ   = 3'd2;
  localparam logic [2:0] LC_SEED = 3'd3;
  localparam logic [2:0] LC_CUBE = 3'd4;

  logic [4:0]  state_r;
  logic [1:0]  ax_r;
  logic [31:0] coord_r [3];
  logic [KW-1:0] k_r;
  logic [KW-1:0] e_r;
  logic signed [15:0] cell_r [3];
  logic [15:0] frac_r [3];
  logic [27:0] lo_r [3];
  logic [28:0] hi_r [3];
  logic [63:0] mul_r;
  logic [4:0]  n_r;
  logic [31:0] acc_r;
  logic [31:0] seed_r;
  logic [2:0]  cnt_r;
  logic [2:0]  j_r;
  logic [2:0]  lc_r;
  logic [31:0] id_r;
  logic [15:0] f_r [3];
  logic signed [1:0] off_r [3];
  logic signed [DELTA_W-1:0] d_r [3];
  logic [35:0] sq_r;

  logic [31:0] best_d_r  [NEAR_SLOTS];
  logic [31:0] best_id_r [NEAR_SLOTS];
  logic signed [DELTA_W-1:0] best_x_r [NEAR_SLOTS];
  logic signed [DELTA_W-1:0] best_y_r [NEAR_SLOTS];
  logic signed [DELTA_W-1:0] best_z_r [NEAR_SLOTS];

  logic [31:0] mul_a, mul_b;
  logic [47:0] prod48;
  logic [31:0] s_val;
  cnkn_off_t   cur_off;
  logic [30:0] bound;
  logic        visit;
  logic [KW-1:0] km1;
  logic [IW-1:0] kidx, eidx;
  logic [31:0] cube_x, cube_y, cube_z;
  logic [31:0] hsum, lcg_nv;
  logic [31:0] d2;
  logic [16:0] hi_base;

  assign km1  = k_r - 1'b1;
  assign kidx = km1[IW-1:0];
  assign eidx = e_r[IW-1:0];
  assign cur_off = cnkn_offset(n_r);
  assign cube_x = 32'(cell_r[0]) + 32'(cur_off.x);
  assign cube_y = 32'(cell_r[1]) + 32'(off_r[1]);
  assign cube_z = 32'(cell_r[2]) + 32'(off_r[2]);
  assign hsum   = acc_r + mul_r[31:0];
  assign lcg_nv = mul_r[31:0] + LCG_ADD;
  assign d2     = sq_r[35:4];
  assign hi_base = 17'h1_0000 - {1'b0, frac_r[ax_r]};
  assign prod48 = mul_r[47:0] - (coord_r[ax_r][31] ? {DENSITY_Q16, 32'b0} : 48'b0);
  assign s_val  = prod48[47:16];

  always_comb begin
    bound = '0;
    if (cur_off.x == OFF_M) bound = bound + 31'(lo_r[0]);
    else if (cur_off.x == OFF_P) bound = bound + 31'(hi_r[0]);
    if (cur_off.y == OFF_M) bound = bound + 31'(lo_r[1]);
    else if (cur_off.y == OFF_P) bound = bound + 31'(hi_r[1]);
    if (cur_off.z == OFF_M) bound = bound + 31'(lo_r[2]);
    else if (cur_off.z == OFF_P) bound = bound + 31'(hi_r[2]);
  end
  assign visit = {1'b0, bound} < best_d_r[kidx];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SC:   begin mul_a = coord_r[ax_r]; mul_b = {16'b0, DENSITY_Q16}; end
      ST_LOI:  begin mul_a = {16'b0, frac_r[ax_r]}; mul_b = {16'b0, frac_r[ax_r]}; end
      ST_LOW:  begin mul_a = {15'b0, hi_base}; mul_b = {15'b0, hi_base}; end
      ST_CUBE: begin mul_a = cube_x; mul_b = HASH_X; end
      ST_H1:   begin mul_a = cube_y; mul_b = HASH_Y; end
      ST_H2:   begin mul_a = cube_z; mul_b = HASH_Z; end
      ST_LI:   begin mul_a = seed_r; mul_b = LCG_MUL; end
      ST_Q0:   begin mul_a = 32'(cnkn_mag(d_r[0])); mul_b = 32'(cnkn_mag(d_r[0])); end
      ST_Q1:   begin mul_a = 32'(cnkn_mag(d_r[1])); mul_b = 32'(cnkn_mag(d_r[1])); end
      ST_Q2:   begin mul_a = 32'(cnkn_mag(d_r[2])); mul_b = 32'(cnkn_mag(d_r[2])); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);
  assign q_valid   = (state_r == ST_EM);

  always_comb begin
    q_data.rank  = 2'(e_r);
    q_data.found = best_d_r[eidx] != EMPTY_DIST;
    q_data.last  = e_r == km1;
    q_data.d2    = best_d_r[eidx];
    q_data.dx    = best_x_r[eidx];
    q_data.dy    = best_y_r[eidx];
    q_data.dz    = best_z_r[eidx];
    q_data.id    = best_id_r[eidx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ax_r    <= '0;
      n_r     <= '0;
      j_r     <= '0;
      lc_r    <= '0;
      e_r     <= '0;
    end else begin
      case (state_r)
        ST_IDLE: if (in_tvalid) begin
          ax_r    <= '0;
          state_r <= ST_SC;
        end
        ST_SC:   state_r <= ST_SCW;
        ST_SCW:  state_r <= ST_LOI;
        ST_LOI:  state_r <= ST_LOW;
        ST_LOW:  state_r <= ST_HIW;
        ST_HIW: begin
          if (ax_r == 2'd2) begin
            n_r     <= '0;
            state_r <= ST_CUBE;
          end else begin
            ax_r    <= ax_r + 2'd1;
            state_r <= ST_SC;
          end
        end
        ST_CUBE: state_r <= visit ? ST_H1 : ST_NXT;
        ST_H1:   state_r <= ST_H2;
        ST_H2:   state_r <= ST_H3;
        ST_H3: begin
          lc_r    <= LC_CUBE;
          state_r <= ST_LI;
        end
        ST_LI:   state_r <= ST_LW;
        ST_LW: begin
          case (lc_r)
            LC_CUBE: begin
              j_r     <= '0;
              state_r <= (cnt_r == 3'd0) ? ST_NXT : ST_PT;
            end
            LC_SEED: state_r <= ST_DX;
            default: begin
              lc_r    <= lc_r + 3'd1;
              state_r <= ST_LI;
            end
          endcase
        end
        ST_PT: begin
          lc_r    <= '0;
          state_r <= ST_LI;
        end
        ST_DX:   state_r <= ST_Q0;
        ST_Q0:   state_r <= ST_Q1;
        ST_Q1:   state_r <= ST_Q2;
        ST_Q2:   state_r <= ST_Q3;
        ST_Q3:   state_r <= ST_INS;
        ST_INS: begin
          j_r     <= j_r + 3'd1;
          state_r <= (j_r + 3'd1 == cnt_r) ? ST_NXT : ST_PT;
        end
        ST_NXT: begin
          if (n_r == LAST_CUBE) begin
            e_r     <= '0;
            state_r <= ST_EM;
          end else begin
            n_r     <= n_r + 5'd1;
            state_r <= ST_CUBE;
          end
        end
        ST_EM: if (q_ready) begin
          if (e_r == km1) state_r <= ST_IDLE;
          else e_r <= e_r + 1'b1;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: if (in_tvalid) begin
        coord_r[0] <= in_tdata[31:0];
        coord_r[1] <= in_tdata[63:32];
        coord_r[2] <= in_tdata[95:64];
        k_r        <= k;
      end
      ST_SCW: begin
        cell_r[ax_r] <= s_val[31:16];
        frac_r[ax_r] <= s_val[15:0];
      end
      ST_LOW: lo_r[ax_r] <= mul_r[31:4];
      ST_HIW: begin
        hi_r[ax_r] <= mul_r[32:4];
        for (int i = 0; i < NEAR_SLOTS; i++) best_d_r[i] <= EMPTY_DIST;
      end
      ST_CUBE: begin
        off_r[0] <= cur_off.x;
        off_r[1] <= cur_off.y;
        off_r[2] <= cur_off.z;
      end
      ST_H1: acc_r <= mul_r[31:0];
      ST_H2: acc_r <= hsum;
      ST_H3: begin
        seed_r <= hsum;
        cnt_r  <= PT_CNT_ROM[hsum[31:24]];
      end
      ST_LW: begin
        seed_r <= lcg_nv;
        if (lc_r <= LC_FZ) f_r[lc_r[1:0]] <= lcg_nv[31:16];
      end
      ST_PT: id_r <= seed_r;
      ST_DX: begin
        for (int a = 0; a < 3; a++) begin
          d_r[a] <= $signed({off_r[a][1], off_r[a], 16'b0}) + $signed({3'b0, f_r[a]})
                    - $signed({3'b0, frac_r[a]});
        end
      end
      ST_Q1: sq_r <= mul_r[35:0];
      ST_Q2: sq_r <= sq_r + mul_r[35:0];
      ST_Q3: sq_r <= sq_r + mul_r[35:0];
      ST_INS: begin
        // sorted list: shift the tail down, drop the new point into its slot
        if (d2 < best_d_r[0]) begin
          best_d_r[0]  <= d2;
          best_id_r[0] <= id_r;
          best_x_r[0]  <= d_r[0];
          best_y_r[0]  <= d_r[1];
          best_z_r[0]  <= d_r[2];
        end
        for (int i = 1; i < NEAR_SLOTS; i++) begin
          if (i < int'(k_r)) begin
            if (d2 < best_d_r[i-1]) begin
              best_d_r[i]  <= best_d_r[i-1];
              best_id_r[i] <= best_id_r[i-1];
              best_x_r[i]  <= best_x_r[i-1];
              best_y_r[i]  <= best_y_r[i-1];
              best_z_r[i]  <= best_z_r[i-1];
            end else if (d2 < best_d_r[i]) begin
              best_d_r[i]  <= d2;
              best_id_r[i] <= id_r;
              best_x_r[i]  <= d_r[0];
              best_y_r[i]  <= d_r[1];
              best_z_r[i]  <= d_r[2];
            end
          end
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/cnkn_queue.sv
module cnkn_queue import cnkn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_valid,
  output logic        wr_ready,
  input  cnkn_entry_t wr_data,
  output logic        rd_valid,
  input  logic        rd_ready,
  output cnkn_entry_t rd_data
);

  cnkn_entry_t    mem_r [QDEPTH];
  logic [QPW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPW:0]   cnt_r;
  logic           push, pop;

  assign wr_ready = cnt_r != (QPW+1)'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

>>> rtl/cnkn_format.sv
module cnkn_format import cnkn_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  output logic         q_ready,
  input  cnkn_entry_t  q_data,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SQRT = 3'd1;
  localparam logic [2:0] F_DINI = 3'd2;
  localparam logic [2:0] F_MUL  = 3'd3;
  localparam logic [2:0] F_FIN  = 3'd4;
  localparam logic [2:0] F_OUT  = 3'd5;

  localparam logic [5:0] SQRT_STEPS = 6'd17;

  // ceil(2^49 / density), exact for 18-bit operands with a 33-bit shift
  localparam logic [34:0] RECIP    = 35'h5_05F4_8F71;
  localparam logic [17:0] RECIP_LO = RECIP[17:0];
  localparam logic [16:0] RECIP_HI = RECIP[34:18];

  logic [2:0]  state_r;
  logic [5:0]  cnt_r;
  cnkn_entry_t ent_r;
  logic [35:0] v_r;
  logic [21:0] rem_r;
  logic [17:0] root_r;
  logic [17:0] x_r   [4];
  logic [35:0] plo_r [4];
  logic [34:0] phi_r [4];
  logic [19:0] dist_r;
  logic [20:0] dlt_r  [3];

  logic [21:0] rem_s, trial;
  logic [53:0] prod [4];
  logic [19:0] sat [4];
  logic        neg [3];

  assign rem_s = {rem_r[19:0], v_r[35:34]};
  assign trial = {2'b0, root_r, 2'b01};

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      prod[l] = {1'b0, phi_r[l], 18'b0} + {18'b0, plo_r[l]};
      sat[l]  = (prod[l][53:33] > {1'b0, OUT_MAX}) ? OUT_MAX : prod[l][52:33];
    end
    neg[0] = ent_r.dx[DELTA_W-1];
    neg[1] = ent_r.dy[DELTA_W-1];
    neg[2] = ent_r.dz[DELTA_W-1];
  end

  assign q_ready    = (state_r == F_IDLE);
  assign out_tvalid = (state_r == F_OUT);
  assign out_tdata  = {5'b0, ent_r.found ? ent_r.id : 32'b0,
                       dlt_r[2], dlt_r[1], dlt_r[0], dist_r};
  assign out_tuser  = {ent_r.found, ent_r.rank};
  assign out_tlast  = ent_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        F_IDLE: if (q_valid) begin
          cnt_r   <= '0;
          state_r <= q_data.found ? F_SQRT : F_OUT;
        end
        F_SQRT: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == SQRT_STEPS) state_r <= F_DINI;
        end
        F_DINI:  state_r <= F_MUL;
        F_MUL:   state_r <= F_FIN;
        F_FIN:   state_r <= F_OUT;
        F_OUT:   if (out_tready) state_r <= F_IDLE;
        default: state_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: if (q_valid) begin
        ent_r  <= q_data;
        v_r    <= {q_data.d2, 4'b0};
        rem_r  <= '0;
        root_r <= '0;
        dist_r <= '0;
        for (int a = 0; a < 3; a++) dlt_r[a] <= '0;
      end
      F_SQRT: begin
        v_r <= {v_r[33:0], 2'b00};
        if (rem_s >= trial) begin
          rem_r  <= rem_s - trial;
          root_r <= {root_r[16:0], 1'b1};
        end else begin
          rem_r  <= rem_s;
          root_r <= {root_r[16:0], 1'b0};
        end
      end
      F_DINI: begin
        x_r[0] <= root_r;
        x_r[1] <= cnkn_mag(ent_r.dx);
        x_r[2] <= cnkn_mag(ent_r.dy);
        x_r[3] <= cnkn_mag(ent_r.dz);
      end
      F_MUL: begin
        for (int l = 0; l < 4; l++) begin
          plo_r[l] <= x_r[l] * RECIP_LO;
          phi_r[l] <= x_r[l] * RECIP_HI;
        end
      end
      F_FIN: begin
        dist_r <= sat[0];
        for (int a = 0; a < 3; a++) begin
          dlt_r[a] <= neg[a] ? -{1'b0, sat[a+1]} : {1'b0, sat[a+1]};
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/cellular_noise_k_nearest_top.sv
// 3d cellular noise, k nearest feature points
// in_*  : one query beat, x, y, z in signed q16.16
// cfg_* : write of the number of ranks reported (0 acts as 1, clamped to NEAR_SLOTS)
// out_* : one beat per rank, rank 0 first, tlast on the final rank of a query
// the search engine takes a query only when idle; set-up, each visited or skipped cube
// and each feature point run in turn on the shared 32x32 multiplier, which carries the
// scaling, bound, hash, lcg and squaring steps one after another
// all ranks go through a 4-beat queue into the formatter, which runs a bit-serial
// square root, then a reciprocal multiply, for each found rank and passes an empty
// rank straight out; it overlaps with the search of the next query
// a stalled out_tready holds the beat; the queue then fills and the search
// waits in its emit phase, no result is lost
// reset clears all control state and sets the rank count to 4; no clearing
// pass is needed
module cellular_noise_k_nearest_top import cnkn_pkg::*; #(
  parameter int NEAR_SLOTS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // coord_x, coord_y, coord_z
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_data,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // distance, delta_x, delta_y, delta_z, feature_id
  output logic [2:0]   out_tuser,  // rank, found
  output logic         out_tlast
);

  localparam int KW = $clog2(NEAR_SLOTS + 1);

  logic [2:0]    order_r;
  logic [KW-1:0] k;
  logic          sq_valid, sq_ready, fq_valid, fq_ready;
  cnkn_entry_t   sq_data, fq_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) order_r <= ORDER_RST;
    else if (cfg_valid) order_r <= cfg_data;
  end

  always_comb begin
    if (order_r == 3'd0) k = KW'(1);
    else if (int'(order_r) > NEAR_SLOTS) k = KW'(NEAR_SLOTS);
    else k = KW'(order_r);
  end

  cnkn_search #(.NEAR_SLOTS(NEAR_SLOTS)) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .k         (k),
    .q_valid   (sq_valid),
    .q_ready   (sq_ready),
    .q_data    (sq_data)
  );

  cnkn_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (sq_valid),
    .wr_ready (sq_ready),
    .wr_data  (sq_data),
    .rd_valid (fq_valid),
    .rd_ready (fq_ready),
    .rd_data  (fq_data)
  );

  cnkn_format u_format (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (fq_valid),
    .q_ready    (fq_ready),
    .q_data     (fq_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> bench/cellular_noise_k_nearest_top_tb.sv
`timescale 1ns / 100ps

module cellular_noise_k_nearest_top_tb;
  import cnkn_pkg::*;

  typedef struct packed {
    logic [1:0]  rank;
    logic [19:0] distance;
    logic [20:0] delta_x;
    logic [20:0] delta_y;
    logic [20:0] delta_z;
    logic [31:0] feature_id;
    logic        found;
    logic        last;
  } rank_beat_t;

  // neighbour cubes: faces, edges, corners
  int nbr_ofs [26][3] = '{
    '{-1,0,0},'{0,-1,0},'{0,0,-1},'{1,0,0},'{0,1,0},'{0,0,1},
    '{-1,-1,0},'{-1,0,-1},'{0,-1,-1},'{1,1,0},'{1,0,1},'{0,1,1},
    '{-1,1,0},'{-1,0,1},'{0,-1,1},'{1,-1,0},'{1,0,-1},'{0,1,-1},
    '{-1,-1,-1},'{-1,-1,1},'{-1,1,-1},'{-1,1,1},'{1,-1,-1},'{1,-1,1},'{1,1,-1},'{1,1,1}};

  logic [2:0] order_seq [8] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6};

  class knn_board;
    logic [2:0]  order_reg;
    int          k;
    logic [31:0] near_d2 [4];
    logic [31:0] near_id [4];
    int          near_dx [4];
    int          near_dy [4];
    int          near_dz [4];
    rank_beat_t  ranks_due [$];
    int          errors;

    function new();
      order_reg = ORDER_RST;
      errors = 0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function logic [31:0] lcg_next(logic [31:0] s);
      return s * LCG_MUL + LCG_ADD;
    endfunction

    function longint unsigned square_mag(int v);
      longint unsigned m;
      m = (v < 0) ? longint'(-longint'(v)) : longint'(v);
      return m * m;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else res >>= 1;
        bitv >>= 2;
      end
      return res;
    endfunction

    function logic [20:0] scale_delta(int v);
      longint unsigned m, q;
      m = (v < 0) ? longint'(-longint'(v)) : longint'(v);
      q = (m << 16) / DENSITY_Q16;
      if (q > 1048575) q = 1048575;
      if (v < 0) q = -q;
      return q[20:0];
    endfunction

    function void visit_cube(longint cx, longint cy, longint cz, int ox, int oy, int oz,
                             logic [15:0] fr [3]);
      logic [31:0] seed, id, d2;
      logic [31:0] cxw, cyw, czw;
      int cnt, idx, dx, dy, dz;
      logic [15:0] fx, fy, fz;
      cxw = cx[31:0];
      cyw = cy[31:0];
      czw = cz[31:0];
      seed = cxw * HASH_X + cyw * HASH_Y + czw * HASH_Z;
      cnt = PT_CNT_ROM[seed[31:24]];
      seed = lcg_next(seed);
      for (int j = 0; j < cnt; j++) begin
        id = seed;
        seed = lcg_next(seed); fx = seed[31:16];
        seed = lcg_next(seed); fy = seed[31:16];
        seed = lcg_next(seed); fz = seed[31:16];
        seed = lcg_next(seed);
        dx = ox * 65536 + int'(fx) - int'(fr[0]);
        dy = oy * 65536 + int'(fy) - int'(fr[1]);
        dz = oz * 65536 + int'(fz) - int'(fr[2]);
        d2 = 32'((square_mag(dx) + square_mag(dy) + square_mag(dz)) >> 4);
        if (d2 >= near_d2[k-1]) continue;
        idx = k;
        while (idx > 0 && d2 < near_d2[idx-1]) idx--;
        for (int i = k - 1; i > idx; i--) begin
          near_d2[i] = near_d2[i-1];
          near_id[i] = near_id[i-1];
          near_dx[i] = near_dx[i-1];
          near_dy[i] = near_dy[i-1];
          near_dz[i] = near_dz[i-1];
        end
        near_d2[idx] = d2;
        near_id[idx] = id;
        near_dx[idx] = dx;
        near_dy[idx] = dy;
        near_dz[idx] = dz;
      end
    endfunction

    function void note_query(logic [31:0] qx, logic [31:0] qy, logic [31:0] qz);
      logic [31:0] c [3];
      longint cube_pos [3];
      logic [15:0] fr [3];
      logic [31:0] lo [3], hi [3], bound;
      longint prod, s;
      longint unsigned root, dist_q;
      rank_beat_t b;
      c[0] = qx; c[1] = qy; c[2] = qz;
      k = (order_reg == 0) ? 1 : (order_reg > 4) ? 4 : order_reg;
      for (int a = 0; a < 3; a++) begin
        prod = longint'($signed(c[a])) * longint'(DENSITY_Q16);
        s = prod >>> 16;
        cube_pos[a] = s >>> 16;
        fr[a] = s[15:0];
        lo[a] = 32'((longint'(fr[a]) * longint'(fr[a])) >> 4);
        hi[a] = 32'(((65536 - longint'(fr[a])) * (65536 - longint'(fr[a]))) >> 4);
      end
      for (int i = 0; i < 4; i++) near_d2[i] = EMPTY_DIST;
      visit_cube(cube_pos[0], cube_pos[1], cube_pos[2], 0, 0, 0, fr);
      for (int n = 0; n < 26; n++) begin
        bound = 0;
        for (int a = 0; a < 3; a++) begin
          if (nbr_ofs[n][a] < 0) bound += lo[a];
          else if (nbr_ofs[n][a] > 0) bound += hi[a];
        end
        if (bound < near_d2[k-1])
          visit_cube(cube_pos[0] + nbr_ofs[n][0], cube_pos[1] + nbr_ofs[n][1],
                     cube_pos[2] + nbr_ofs[n][2], nbr_ofs[n][0], nbr_ofs[n][1],
                     nbr_ofs[n][2], fr);
      end
      for (int i = 0; i < k; i++) begin
        b = '0;
        b.rank = i[1:0];
        b.found = near_d2[i] != EMPTY_DIST;
        b.last = (i + 1 == k);
        if (b.found) begin
          root = int_sqrt(longint'(near_d2[i]) << 4);
          dist_q = (root << 16) / DENSITY_Q16;
          if (dist_q > 1048575) dist_q = 1048575;
          b.distance = dist_q[19:0];
          b.delta_x = scale_delta(near_dx[i]);
          b.delta_y = scale_delta(near_dy[i]);
          b.delta_z = scale_delta(near_dz[i]);
          b.feature_id = near_id[i];
        end
        ranks_due.push_back(b);
      end
    endfunction

    task check_beat(rank_beat_t got);
      rank_beat_t want;
      if (ranks_due.size() == 0) begin
        report("result beat with nothing pending");
        return;
      end
      want = ranks_due.pop_front();
      if (got.rank != want.rank)
        report($sformatf("rank %0d, wanted %0d", got.rank, want.rank));
      if (got.distance != want.distance)
        report($sformatf("distance %h, wanted %h", got.distance, want.distance));
      if (got.delta_x != want.delta_x)
        report($sformatf("delta_x %h, wanted %h", got.delta_x, want.delta_x));
      if (got.delta_y != want.delta_y)
        report($sformatf("delta_y %h, wanted %h", got.delta_y, want.delta_y));
      if (got.delta_z != want.delta_z)
        report($sformatf("delta_z %h, wanted %h", got.delta_z, want.delta_z));
      if (got.feature_id != want.feature_id)
        report($sformatf("feature_id %h, wanted %h", got.feature_id, want.feature_id));
      if (got.found != want.found)
        report($sformatf("found %0d, wanted %0d", got.found, want.found));
      if (got.last != want.last)
        report($sformatf("last %0d, wanted %0d", got.last, want.last));
    endtask
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_data;
  logic         out_tvalid;
  logic         out_tready;
  logic [119:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;

  knn_board board;
  bit       calm;
  int       hold_left = 0;

  cellular_noise_k_nearest_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // result side: check each beat, then draw the next stall
  always @(posedge clk) begin
    rank_beat_t got;
    logic next_ready;
    next_ready = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.rank = out_tuser[1:0];
        got.found = out_tuser[2];
        got.last = out_tlast;
        got.distance = out_tdata[19:0];
        got.delta_x = out_tdata[40:20];
        got.delta_y = out_tdata[61:41];
        got.delta_z = out_tdata[82:62];
        got.feature_id = out_tdata[114:83];
        board.check_beat(got);
        hold_left = calm ? 0 : $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        next_ready = 1'b0;
        hold_left--;
      end else next_ready = 1'b1;
    end
    out_tready <= next_ready;
  end

  task automatic send_query(logic [31:0] qx, logic [31:0] qy, logic [31:0] qz);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {qz, qy, qx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_query(qx, qy, qz);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.ranks_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_order(logic [2:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.order_reg = value;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6:    return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      7:          return {16'($urandom_range(0, 255) - 128), 16'h0000} ^ ($urandom() & 32'h3);
      8:          return {16'h7FFF, 16'($urandom())};
      default:    return {16'h8000, 16'($urandom())};
    endcase
  endfunction

  initial begin
    board = new();
    calm = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners of the coordinate range, origin, cube edges
    send_query(32'h0, 32'h0, 32'h0);
    send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_query(32'h0001_0000, 32'hFFFF_0000, 32'h0002_7400);
    send_query(32'h0002_7463, 32'h0002_7464, 32'hFFFD_8B9C);
    send_query(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0);
    send_query(32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_8000);
    send_query(32'h4000_0000, 32'hC000_0000, 32'h1234_5678);

    for (int p = 0; p < 8; p++) begin
      if (p > 0) write_order(order_seq[p]);
      calm = (p == 3) || (p == 6);
      for (int n = 0; n < 25; n++) send_query(pick_coord(), pick_coord(), pick_coord());
    end
    write_order(3'd4);
    send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);

    drain();
    if (board.errors == 0) begin
      $display("cellular_noise_k_nearest_top regression: pass");
    end else begin
      $display("cellular_noise_k_nearest_top regression: fail");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("cellular_noise_k_nearest_top regression: fail");
    $finish;
  end

endmodule

>>> cellular_noise_k_nearest_top.f
rtl/cnkn_pkg.sv
rtl/cnkn_search.sv
rtl/cnkn_queue.sv
rtl/cnkn_format.sv
rtl/cellular_noise_k_nearest_top.sv
bench/cellular_noise_k_nearest_top_tb.sv
